// File: rtl/core/clcd_pkg.sv
// clcd_pkg: shared types, codes and constant tables of the character LCD
// bus write sequencer. Used by every file in rtl/core; depends on nothing.

package clcd_pkg;

  // Request kinds
  localparam logic [2:0] REQ_INIT   = 3'd0;
  localparam logic [2:0] REQ_CMD    = 3'd1;
  localparam logic [2:0] REQ_DATA   = 3'd2;
  localparam logic [2:0] REQ_CURSOR = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;
  localparam logic [2:0] REQ_GLYPH  = 3'd5;

  // Configuration register indexes
  localparam logic REG_BUS_MODE   = 1'b0;
  localparam logic REG_ROW_LAYOUT = 1'b1;

  // Controller command bytes
  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_DDRAM = 8'h80;
  localparam logic [7:0] CMD_CGRAM = 8'h40;

  // Which part of the byte a step drives
  localparam logic [1:0] PART_HI   = 2'd0;
  localparam logic [1:0] PART_LO   = 2'd1;
  localparam logic [1:0] PART_FULL = 2'd2;

  // Byte source of a step
  localparam logic SRC_IMM  = 1'b0;
  localparam logic SRC_OPND = 1'b1;

  // Branch condition of a step
  localparam logic COND_NEXT   = 1'b0;
  localparam logic COND_NOINIT = 1'b1;

  // Pre-wait codes
  localparam logic [2:0] WAIT_NONE  = 3'd0;
  localparam logic [2:0] WAIT_15200 = 3'd1;
  localparam logic [2:0] WAIT_4200  = 3'd2;
  localparam logic [2:0] WAIT_200   = 3'd3;
  localparam logic [2:0] WAIT_1600  = 3'd4;

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  // Program entry points
  localparam pc_t PC_INIT4  = pc_t'(0);
  localparam pc_t PC_INIT8  = pc_t'(12);
  localparam pc_t PC_CMD4   = pc_t'(19);
  localparam pc_t PC_CMD4LO = pc_t'(21);
  localparam pc_t PC_CMD8   = pc_t'(22);
  localparam pc_t PC_DATA4  = pc_t'(23);
  localparam pc_t PC_DATA8  = pc_t'(25);
  localparam pc_t PC_LAST   = pc_t'(25);

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] byte_value;
    logic [1:0] cursor_row;
    logic [4:0] cursor_col;
    logic [2:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic        reg_select;
    logic [7:0]  bus_value;
    logic        bus_width;
    logic [13:0] wait_before_us;
    logic        last;
  } out_item_t;

  // One control word of the sequencer program
  typedef struct packed {
    logic       emit;
    logic [1:0] part;
    logic       src;
    logic       rs;
    logic [7:0] imm;
    logic [2:0] wait_code;
    logic       set_init;
    logic       last;
    logic       cond;
    pc_t        target;
  } ucode_t;

  typedef struct packed {
    logic load_opnd;
    logic load_out;
  } dp_ctl_t;

  function automatic logic [13:0] wait_us(input logic [2:0] code);
    logic [13:0] us;
    case (code)
      WAIT_15200: us = 14'd15200;
      WAIT_4200:  us = 14'd4200;
      WAIT_200:   us = 14'd200;
      WAIT_1600:  us = 14'd1600;
      default:    us = 14'd0;
    endcase
    return us;
  endfunction

  function automatic logic [7:0] row_offset(input logic layout20, input logic [1:0] row);
    logic [7:0] off;
    case (row)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = layout20 ? 8'h14 : 8'h10;
      default: off = layout20 ? 8'h54 : 8'h50;
    endcase
    return off;
  endfunction

  function automatic pc_t entry_pc(input logic [2:0] req, input logic bus8);
    pc_t pc;
    case (req)
      REQ_INIT: pc = bus8 ? PC_INIT8 : PC_INIT4;
      REQ_DATA: pc = bus8 ? PC_DATA8 : PC_DATA4;
      default:  pc = bus8 ? PC_CMD8 : PC_CMD4;
    endcase
    return pc;
  endfunction

  function automatic logic req_known(input logic [2:0] req);
    logic known;
    case (req)
      REQ_INIT, REQ_CMD, REQ_DATA, REQ_CURSOR, REQ_CLEAR, REQ_GLYPH: known = 1'b1;
      default: known = 1'b0;
    endcase
    return known;
  endfunction

endpackage

// File: rtl/core/clcd_ucode_rom.sv
// clcd_ucode_rom: read-only sequencer program, one control word per step.
// Depends on clcd_pkg.

module clcd_ucode_rom
  import clcd_pkg::*;
(
  input  pc_t    pc,
  output ucode_t uword
);

  function automatic ucode_t uw(input int emit, input logic [1:0] part, input logic src,
                                input int rs, input logic [7:0] imm,
                                input logic [2:0] wcode, input int set_init,
                                input int last, input logic cond, input pc_t target);
    ucode_t w;
    w.emit      = emit[0];
    w.part      = part;
    w.src       = src;
    w.rs        = rs[0];
    w.imm       = imm;
    w.wait_code = wcode;
    w.set_init  = set_init[0];
    w.last      = last[0];
    w.cond      = cond;
    w.target    = target;
    return w;
  endfunction

  always_comb begin
    case (pc)
      // init program, four-bit bus
      5'd0:  uword = uw(1, PART_LO, SRC_IMM, 0, 8'h03, WAIT_15200, 0, 0, COND_NEXT, '0);
      5'd1:  uword = uw(1, PART_LO, SRC_IMM, 0, 8'h03, WAIT_4200, 0, 0, COND_NEXT, '0);
      5'd2:  uword = uw(1, PART_LO, SRC_IMM, 0, 8'h03, WAIT_200, 0, 0, COND_NEXT, '0);
      5'd3:  uword = uw(1, PART_LO, SRC_IMM, 0, 8'h02, WAIT_NONE, 1, 0, COND_NEXT, '0);
      5'd4:  uword = uw(1, PART_HI, SRC_IMM, 0, 8'h28, WAIT_NONE, 0, 0, COND_NEXT, '0);
      5'd5:  uword = uw(1, PART_LO, SRC_IMM, 0, 8'h28, WAIT_NONE, 0, 0, COND_NEXT, '0);
      5'd6:  uword = uw(1, PART_HI, SRC_IMM, 0, 8'h01, WAIT_NONE, 0, 0, COND_NEXT, '0);
      5'd7:  uword = uw(1, PART_LO, SRC_IMM, 0, 8'h01, WAIT_NONE, 0, 0, COND_NEXT, '0);
      5'd8:  uword = uw(1, PART_HI, SRC_IMM, 0, 8'h0C, WAIT_1600, 0, 0, COND_NEXT, '0);
      5'd9:  uword = uw(1, PART_LO, SRC_IMM, 0, 8'h0C, WAIT_NONE, 0, 0, COND_NEXT, '0);
      5'd10: uword = uw(1, PART_HI, SRC_IMM, 0, 8'h06, WAIT_NONE, 0, 0, COND_NEXT, '0);
      5'd11: uword = uw(1, PART_LO, SRC_IMM, 0, 8'h06, WAIT_NONE, 0, 1, COND_NEXT, '0);
      // init program, eight-bit bus
      5'd12: uword = uw(1, PART_FULL, SRC_IMM, 0, 8'h30, WAIT_15200, 0, 0, COND_NEXT, '0);
      5'd13: uword = uw(1, PART_FULL, SRC_IMM, 0, 8'h30, WAIT_4200, 0, 0, COND_NEXT, '0);
      5'd14: uword = uw(1, PART_FULL, SRC_IMM, 0, 8'h30, WAIT_200, 1, 0, COND_NEXT, '0);
      5'd15: uword = uw(1, PART_FULL, SRC_IMM, 0, 8'h38, WAIT_NONE, 0, 0, COND_NEXT, '0);
      5'd16: uword = uw(1, PART_FULL, SRC_IMM, 0, 8'h01, WAIT_NONE, 0, 0, COND_NEXT, '0);
      5'd17: uword = uw(1, PART_FULL, SRC_IMM, 0, 8'h0C, WAIT_1600, 0, 0, COND_NEXT, '0);
      5'd18: uword = uw(1, PART_FULL, SRC_IMM, 0, 8'h06, WAIT_NONE, 0, 1, COND_NEXT, '0);
      // command, four-bit bus: skip the high nibble until initialized
      5'd19: uword = uw(0, PART_LO, SRC_OPND, 0, 8'h00, WAIT_NONE, 0, 0, COND_NOINIT,
                        PC_CMD4LO);
      5'd20: uword = uw(1, PART_HI, SRC_OPND, 0, 8'h00, WAIT_NONE, 0, 0, COND_NEXT, '0);
      5'd21: uword = uw(1, PART_LO, SRC_OPND, 0, 8'h00, WAIT_NONE, 0, 1, COND_NEXT, '0);
      // command, eight-bit bus
      5'd22: uword = uw(1, PART_FULL, SRC_OPND, 0, 8'h00, WAIT_NONE, 0, 1, COND_NEXT, '0);
      // data
      5'd23: uword = uw(1, PART_HI, SRC_OPND, 1, 8'h00, WAIT_NONE, 0, 0, COND_NEXT, '0);
      5'd24: uword = uw(1, PART_LO, SRC_OPND, 1, 8'h00, WAIT_NONE, 0, 1, COND_NEXT, '0);
      5'd25: uword = uw(1, PART_FULL, SRC_OPND, 1, 8'h00, WAIT_NONE, 0, 1, COND_NEXT, '0);
      // unused steps end the program without a transfer
      default: uword = uw(0, PART_FULL, SRC_IMM, 0, 8'h00, WAIT_NONE, 0, 1, COND_NEXT, '0);
    endcase
  end

endmodule

// File: rtl/core/clcd_datapath.sv
// clcd_datapath: operand register (command, data, cursor, clear or glyph byte) and the
// transfer register formed from the current control word. Depends on clcd_pkg.

module clcd_datapath
  import clcd_pkg::*;
(
  input  logic      clk,
  input  dp_ctl_t   ctl,
  input  in_item_t  in_item,
  input  logic      row_layout,
  input  ucode_t    uword,
  output out_item_t out_item
);

  logic [7:0] opnd_r;
  logic [7:0] opnd_nxt;
  logic [7:0] src_byte;
  out_item_t  out_r;
  out_item_t  out_nxt;

  always_comb begin
    case (in_item.req_type)
      REQ_CURSOR: opnd_nxt = CMD_DDRAM + row_offset(row_layout, in_item.cursor_row)
                             + {3'b000, in_item.cursor_col};
      REQ_CLEAR:  opnd_nxt = CMD_CLEAR;
      REQ_GLYPH:  opnd_nxt = CMD_CGRAM + {2'b00, in_item.char_code, 3'b000};
      default:    opnd_nxt = in_item.byte_value;
    endcase
  end

  assign src_byte = (uword.src == SRC_OPND) ? opnd_r : uword.imm;

  always_comb begin
    out_nxt.reg_select     = uword.rs;
    out_nxt.wait_before_us = wait_us(uword.wait_code);
    out_nxt.last           = uword.last;
    case (uword.part)
      PART_HI: begin
        out_nxt.bus_value = {4'h0, src_byte[7:4]};
        out_nxt.bus_width = 1'b0;
      end
      PART_LO: begin
        out_nxt.bus_value = {4'h0, src_byte[3:0]};
        out_nxt.bus_width = 1'b0;
      end
      default: begin
        out_nxt.bus_value = src_byte;
        out_nxt.bus_width = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load_opnd) begin
      opnd_r <= opnd_nxt;
    end
    if (ctl.load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;

endmodule

// File: rtl/core/char_lcd_bus_write_sequencer.sv
// char_lcd_bus_write_sequencer: top level; step counter, branch logic,
// handshakes and configuration. Depends on clcd_pkg, clcd_ucode_rom, clcd_datapath.

// Each accepted request becomes a list of enable-strobed LCD bus transfers,
// one per result transaction; the final one carries last. A microprogram in a
// read-only table drives the transfers one step at a time: the step counter
// emits at most one transfer per cycle into the output register, holding a
// transfer step while that register is full and not being drained. A four-bit
// command runs one extra silent step first (the initialized check). The next
// request is taken once the last transfer sits in the output register. Unknown
// request kinds are taken and dropped. Every transfer carries its pre-wait in
// microseconds; the fixed 50 us hold after each strobe is up to the pin driver
// and is not in the wait field. Configuration writes (bus_mode, row_layout) are
// always ready and belong in idle time.

module char_lcd_bus_write_sequencer
  import clcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic      cfg_data
);

  logic    busy_r, busy_nxt;
  pc_t     pc_r, pc_nxt;
  logic    init_r, init_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    bus_mode_r, row_layout_r;
  ucode_t  uword;
  dp_ctl_t ctl;
  logic    in_accept;
  logic    out_free;
  logic    step_go;
  logic    emit_go;

  clcd_ucode_rom u_rom (
    .pc    (pc_r),
    .uword (uword)
  );

  clcd_datapath u_dp (
    .clk        (clk),
    .ctl        (ctl),
    .in_item    (in_data),
    .row_layout (row_layout_r),
    .uword      (uword),
    .out_item   (out_data)
  );

  assign in_ready  = !busy_r;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || out_ready;
  // Advance on a silent step at once, on a transfer step only when it can land.
  assign step_go  = busy_r && (!uword.emit || out_free);
  assign emit_go  = step_go && uword.emit;

  assign ctl.load_opnd = in_accept;
  assign ctl.load_out  = emit_go;

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    init_nxt = init_r;
    if (in_accept) begin
      busy_nxt = req_known(in_data.req_type);
      pc_nxt   = entry_pc(in_data.req_type, bus_mode_r);
      // init drops the initialized flag until its program sets it again
      if (in_data.req_type == REQ_INIT) begin
        init_nxt = 1'b0;
      end
    end else if (step_go) begin
      if (uword.set_init) begin
        init_nxt = 1'b1;
      end
      if (uword.last) begin
        busy_nxt = 1'b0;
      end else if (uword.cond == COND_NOINIT && !init_r) begin
        pc_nxt = uword.target;
      end else begin
        pc_nxt = pc_r + pc_t'(1);
      end
    end
  end

  always_comb begin
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      pc_r         <= '0;
      init_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      bus_mode_r   <= 1'b0;
      row_layout_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BUS_MODE:   bus_mode_r   <= cfg_data;
          REG_ROW_LAYOUT: row_layout_r <= cfg_data;
          default:        bus_mode_r   <= bus_mode_r;
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  // hold the step counter inside the program while running
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pc_r <= PC_LAST)
    else $error("step counter outside program");

  // drop busy right after the final step advances
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    step_go && uword.last |=> !busy_r)
    else $error("sequencer still busy after last step");

  // nibble transfers keep the upper data pins low
  a_nibble_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data.bus_width |-> out_data.bus_value[7:4] == 4'h0)
    else $error("nibble transfer with upper bits set");

  // init starts the program with the initialized flag cleared
  a_init_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.req_type == REQ_INIT |=> busy_r && !init_r)
    else $error("init request did not start cleanly");
`endif

endmodule

// File: tb/testbench.sv
// testbench: self-checking bench for char_lcd_bus_write_sequencer.
// Predicts the bus transfers of every accepted LCD request in a small scoreboard
// class and checks each result transaction; depends on clcd_pkg and the RTL.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import clcd_pkg::*;

  // Request kinds the block must take and drop without any transfer
  localparam logic [2:0] REQ_RSVD6 = 3'd6;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;

  // Controller command bytes used by the power-on program
  localparam logic [7:0] WAKE_NIBBLE   = 8'h03;
  localparam logic [7:0] NIBBLE_SELECT = 8'h02;
  localparam logic [7:0] WAKE_BYTE     = 8'h30;
  localparam logic [7:0] FUNC_SET_4BIT = 8'h28;
  localparam logic [7:0] FUNC_SET_8BIT = 8'h38;
  localparam logic [7:0] DISPLAY_ON    = 8'h0C;
  localparam logic [7:0] ENTRY_INC     = 8'h06;

  // Pre-strobe waits in microseconds
  localparam logic [13:0] US_NONE      = 14'd0;
  localparam logic [13:0] US_POWER_UP  = 14'd15200;
  localparam logic [13:0] US_WAKE_2ND  = 14'd4200;
  localparam logic [13:0] US_WAKE_3RD  = 14'd200;
  localparam logic [13:0] US_DISPLAYON = 14'd1600;

  // Run shape
  localparam int RESET_CYCLES    = 10;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 57;
  localparam int PRESSURE_PHASE  = 5;
  localparam int DRAIN_PHASE     = 2;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 30;
  localparam int CYCLE_LIMIT     = 600000;

  // Expected-transfer tracker: keeps its own copy of bus mode, row layout and
  // the initialized flag, and expands each request into its bus transfers.
  class transfer_scoreboard;
    bit        bus8;
    bit        layout20;
    bit        init_done;
    out_item_t expected_q[$];
    out_item_t batch[$];
    int        errors;
    int        requests_seen;
    int        transfers_checked;

    function int outstanding();
      return expected_q.size();
    endfunction

    function void write_register(logic idx, logic val);
      if (idx == REG_BUS_MODE) bus8 = val;
      else layout20 = val;
    endfunction

    function void push_xfer(logic rs, logic [7:0] val, logic wide, logic [13:0] us);
      out_item_t t;
      t.reg_select     = rs;
      t.bus_value      = val;
      t.bus_width      = wide;
      t.wait_before_us = us;
      t.last           = 1'b0;
      batch.push_back(t);
    endfunction

    // Before init completes a four-bit command carries only its low nibble
    function void put_command(logic [7:0] cmd, logic [13:0] us);
      if (!bus8) begin
        if (init_done) begin
          push_xfer(1'b0, {4'h0, cmd[7:4]}, 1'b0, us);
          us = US_NONE;
        end
        push_xfer(1'b0, {4'h0, cmd[3:0]}, 1'b0, us);
      end else begin
        push_xfer(1'b0, cmd, 1'b1, us);
      end
    endfunction

    function void put_data(logic [7:0] d);
      if (!bus8) begin
        push_xfer(1'b1, {4'h0, d[7:4]}, 1'b0, US_NONE);
        push_xfer(1'b1, {4'h0, d[3:0]}, 1'b0, US_NONE);
      end else begin
        push_xfer(1'b1, d, 1'b1, US_NONE);
      end
    endfunction

    function void power_on_program();
      init_done = 1'b0;
      if (!bus8) begin
        put_command(WAKE_NIBBLE, US_POWER_UP);
        put_command(WAKE_NIBBLE, US_WAKE_2ND);
        put_command(WAKE_NIBBLE, US_WAKE_3RD);
        put_command(NIBBLE_SELECT, US_NONE);
        init_done = 1'b1;
        put_command(FUNC_SET_4BIT, US_NONE);
      end else begin
        put_command(WAKE_BYTE, US_POWER_UP);
        put_command(WAKE_BYTE, US_WAKE_2ND);
        put_command(WAKE_BYTE, US_WAKE_3RD);
        init_done = 1'b1;
        put_command(FUNC_SET_8BIT, US_NONE);
      end
      put_command(CMD_CLEAR, US_NONE);
      put_command(DISPLAY_ON, US_DISPLAYON);
      put_command(ENTRY_INC, US_NONE);
    endfunction

    function logic [7:0] row_base(logic [1:0] row);
      logic [7:0] base;
      case (row)
        2'd0:    base = 8'h00;
        2'd1:    base = 8'h40;
        2'd2:    base = layout20 ? 8'h14 : 8'h10;
        default: base = layout20 ? 8'h54 : 8'h50;
      endcase
      return base;
    endfunction

    function void note_request(in_item_t r);
      out_item_t t;
      logic [7:0] addr;
      batch.delete();
      requests_seen++;
      case (r.req_type)
        REQ_INIT:   power_on_program();
        REQ_CMD:    put_command(r.byte_value, US_NONE);
        REQ_DATA:   put_data(r.byte_value);
        REQ_CURSOR: begin
          addr = CMD_DDRAM + row_base(r.cursor_row) + {3'b000, r.cursor_col};
          put_command(addr, US_NONE);
        end
        REQ_CLEAR:  put_command(CMD_CLEAR, US_NONE);
        REQ_GLYPH:  put_command(CMD_CGRAM + {2'b00, r.char_code, 3'b000}, US_NONE);
        default:    ;
      endcase
      if (batch.size() > 0) begin
        t = batch.pop_back();
        t.last = 1'b1;
        batch.push_back(t);
      end
      foreach (batch[i]) expected_q.push_back(batch[i]);
    endfunction

    function void report(string field, logic [13:0] want, logic [13:0] seen);
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, seen);
    endfunction

    function void check_transfer(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer rs=%0b value=0x%0h width=%0b wait=%0d last=%0b",
                 $time, got.reg_select, got.bus_value, got.bus_width,
                 got.wait_before_us, got.last);
        return;
      end
      want = expected_q.pop_front();
      transfers_checked++;
      if (got.reg_select !== want.reg_select)
        report("reg_select", 14'(want.reg_select), 14'(got.reg_select));
      if (got.bus_value !== want.bus_value)
        report("bus_value", 14'(want.bus_value), 14'(got.bus_value));
      if (got.bus_width !== want.bus_width)
        report("bus_width", 14'(want.bus_width), 14'(got.bus_width));
      if (got.wait_before_us !== want.wait_before_us)
        report("wait_before_us", want.wait_before_us, got.wait_before_us);
      if (got.last !== want.last)
        report("last", 14'(want.last), 14'(got.last));
    endfunction
  endclass

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_index = 1'b0;
  logic      cfg_data  = 1'b0;

  // Handshake flags between the stimulus and the result sink
  bit hold_off_req = 1'b0;
  bit calm         = 1'b0;

  transfer_scoreboard sb = new();

  char_lcd_bus_write_sequencer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout with %0d transfers still expected", $time, sb.outstanding());
    $display("FAIL");
    $finish;
  end

  // Monitors: sample every handshake at the edge, before any driver update lands
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_transfer(out_data);
    end
  end

  // Result sink: random ready bursts and stalls, one long hold-off on request,
  // and steady ready once the run turns calm.
  initial begin : result_sink
    int span;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        span = $urandom_range(1, 18);
        repeat (span) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        span = $urandom_range(1, 40);
        repeat (span) @(posedge clk);
      end
    end
  end

  function automatic in_item_t item_of(logic [2:0] req, logic [7:0] val, logic [1:0] row,
                                       logic [4:0] col, logic [2:0] code);
    in_item_t it;
    it.req_type   = req;
    it.byte_value = val;
    it.cursor_row = row;
    it.cursor_col = col;
    it.char_code  = code;
    return it;
  endfunction

  // Weighted request mix; every field carries random content regardless of kind
  function automatic in_item_t random_request();
    in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.byte_value = 8'($urandom_range(0, 255));
    it.cursor_row = 2'($urandom_range(0, 3));
    it.cursor_col = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(0, 19));
    it.char_code  = 3'($urandom_range(0, 7));
    if (pick < 5)       it.req_type = REQ_INIT;
    else if (pick < 25) it.req_type = REQ_CMD;
    else if (pick < 55) it.req_type = REQ_DATA;
    else if (pick < 75) it.req_type = REQ_CURSOR;
    else if (pick < 83) it.req_type = REQ_CLEAR;
    else if (pick < 96) it.req_type = REQ_GLYPH;
    else                it.req_type = pick[0] ? REQ_RSVD7 : REQ_RSVD6;
    return it;
  endfunction

  // Offer one request, maybe after an idle burst; valid is left high on return
  task automatic offer(input in_item_t item, input int gap_pct);
    int gap;
    if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Wait for every expected transfer, then let a dropped request finish too.
  // Wait on the clock first so the monitor has noted the last accepted request.
  task automatic settle();
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back with valid held high
  task automatic apply_setup(input logic bus_sel, input logic lay_sel);
    cfg_valid <= 1'b1;
    cfg_index <= REG_BUS_MODE;
    cfg_data  <= bus_sel;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_ROW_LAYOUT;
    cfg_data  <= lay_sel;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int p;
    int n;
    int gap_pct;
    logic bus_sel;
    logic lay_sel;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings: four-bit bus, 16-column rows, not
    // initialized. Commands go out as a lone low nibble until init runs.
    offer(item_of(REQ_CMD,    8'hA5, 2'd0, 5'd0,  3'd0), 0);
    offer(item_of(REQ_CURSOR, 8'h00, 2'd3, 5'd19, 3'd0), 0);
    offer(item_of(REQ_CLEAR,  8'hFF, 2'd3, 5'd31, 3'd7), 0);
    offer(item_of(REQ_DATA,   8'hFF, 2'd0, 5'd0,  3'd0), 0);
    offer(item_of(REQ_DATA,   8'h00, 2'd3, 5'd31, 3'd7), 0);
    offer(item_of(REQ_RSVD6,  8'hFF, 2'd3, 5'd31, 3'd7), 0);
    offer(item_of(REQ_RSVD7,  8'h00, 2'd0, 5'd0,  3'd0), 0);
    offer(item_of(REQ_INIT,   8'h00, 2'd0, 5'd0,  3'd0), 0);
    offer(item_of(REQ_CMD,    8'hFF, 2'd0, 5'd0,  3'd0), 0);
    offer(item_of(REQ_CMD,    8'h00, 2'd0, 5'd0,  3'd0), 0);
    offer(item_of(REQ_CURSOR, 8'h00, 2'd3, 5'd31, 3'd0), 0);
    offer(item_of(REQ_CURSOR, 8'h00, 2'd0, 5'd0,  3'd0), 0);
    offer(item_of(REQ_GLYPH,  8'h00, 2'd0, 5'd0,  3'd7), 0);
    offer(item_of(REQ_GLYPH,  8'h00, 2'd0, 5'd0,  3'd0), 0);
    offer(item_of(REQ_CURSOR, 8'h00, 2'd2, 5'd19, 3'd0), 0);
    in_valid <= 1'b0;
    settle();

    // Eight-bit bus with 20-column rows; init runs its shorter program
    apply_setup(1'b1, 1'b1);
    offer(item_of(REQ_CMD,    8'h5A, 2'd0, 5'd0,  3'd0), 0);
    offer(item_of(REQ_INIT,   8'hFF, 2'd3, 5'd31, 3'd7), 0);
    offer(item_of(REQ_DATA,   8'hFF, 2'd0, 5'd0,  3'd0), 0);
    offer(item_of(REQ_CURSOR, 8'h00, 2'd3, 5'd31, 3'd0), 0);
    offer(item_of(REQ_CURSOR, 8'h00, 2'd2, 5'd0,  3'd0), 0);
    offer(item_of(REQ_GLYPH,  8'h00, 2'd0, 5'd0,  3'd7), 0);
    offer(item_of(REQ_CLEAR,  8'h00, 2'd0, 5'd0,  3'd0), 0);
    offer(item_of(REQ_RSVD6,  8'h00, 2'd0, 5'd0,  3'd0), 0);
    in_valid <= 1'b0;

    // Random phases: the four corner settings first, then random ones. One
    // phase runs against a long result hold-off so the block backs up into
    // its input; one drains fully half way; the last runs with no idling.
    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      if (p < 4) begin
        bus_sel = p[0];
        lay_sel = p[1] ^ p[0];
      end else begin
        bus_sel = 1'($urandom_range(0, 1));
        lay_sel = 1'($urandom_range(0, 1));
      end
      apply_setup(bus_sel, lay_sel);
      if (p == PRESSURE_PHASE) hold_off_req = 1'b1;
      if (p == NUM_PHASES - 1) calm = 1'b1;
      gap_pct = (p == 3 || p == PRESSURE_PHASE || calm) ? 0 : 30;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == DRAIN_PHASE && n == ITEMS_PER_PHASE / 2) begin
          // Pause the sender until the block has delivered everything
          in_valid <= 1'b0;
          do @(posedge clk); while (sb.outstanding() != 0);
        end
        offer(random_request(), gap_pct);
      end
      in_valid <= 1'b0;
    end

    settle();

    $display("Run covered %0d requests and %0d checked bus transfers", sb.requests_seen,
             sb.transfers_checked);
    $display("across %0d bus-width and row-layout settings, with stalls on both sides.",
             NUM_PHASES + 2);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: char_lcd_bus_write_sequencer.f
rtl/core/clcd_pkg.sv
rtl/core/clcd_ucode_rom.sv
rtl/core/clcd_datapath.sv
rtl/core/char_lcd_bus_write_sequencer.sv
tb/testbench.sv
